// ===== rtl/g2g_pkg.sv =====
// Package of the go-to-goal steering unit: stage word types, fixed widths
// and the CORDIC arctangent table. No dependencies.
`default_nettype none
package g2g_pkg;

   localparam int unsigned ROOT_BITS = 17;   // floor(sqrt(2 * 65535^2)) < 2^17
   localparam int unsigned SQ_BITS   = 34;
   localparam int unsigned VEC_BITS  = 36;   // offset << 14 plus CORDIC growth
   localparam int unsigned ANG_BITS  = 34;   // 2^31 equals pi
   localparam int unsigned DIV_BITS  = 15;
   localparam int unsigned ATAN_ENTRIES = 24;

   localparam logic [1:0] CSR_ARRIVAL  = 2'd0;
   localparam logic [1:0] CSR_SLOWDOWN = 2'd1;
   localparam logic [1:0] CSR_MAXSPEED = 2'd2;

   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [15:0] ryaw;
      logic signed [15:0] gyaw;
   } g2g_diff_type;

   typedef struct packed {
      logic [SQ_BITS-1:0]          sqx;
      logic [SQ_BITS-1:0]          sqy;
      logic signed [VEC_BITS-1:0]  x;
      logic signed [VEC_BITS-1:0]  y;
      logic signed [ANG_BITS-1:0]  ang;
      logic                        zero;
      logic signed [15:0]          ryaw;
      logic signed [15:0]          gyaw;
   } g2g_front_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0]  x;
      logic signed [VEC_BITS-1:0]  y;
      logic signed [ANG_BITS-1:0]  ang;
      logic                        zero;
      logic [SQ_BITS-1:0]          q;
      logic [ROOT_BITS+3:0]        rem;
      logic [ROOT_BITS-1:0]        root;
      logic signed [15:0]          ryaw;
      logic signed [15:0]          gyaw;
   } g2g_vec_type;

   typedef struct packed {
      logic [31:0]          rem;
      logic [DIV_BITS-1:0]  quo;
      logic                 sat;
      logic [14:0]          maxv;
      logic [15:0]          slow;
      logic signed [15:0]   cmd;
   } g2g_div_type;

   function automatic logic signed [ANG_BITS-1:0] atan_entry(input int unsigned i);
      logic signed [ANG_BITS-1:0] v;
      case (i)
         0:  v = 34'sd536870912;
         1:  v = 34'sd316933406;
         2:  v = 34'sd167458907;
         3:  v = 34'sd85004756;
         4:  v = 34'sd42667331;
         5:  v = 34'sd21354465;
         6:  v = 34'sd10680862;
         7:  v = 34'sd5340245;
         8:  v = 34'sd2670163;
         9:  v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/g2g_vec_stage.sv =====
// One pipeline stage of the vector path: one CORDIC vectoring step and/or one
// square-root digit, as the parameters select. Depends on g2g_pkg.
`default_nettype none
module g2g_vec_stage #(
   parameter int unsigned STEP    = 0,
   parameter bit          DO_ROT  = 1'b1,
   parameter bit          DO_ROOT = 1'b1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_i,
   input  wire g2g_pkg::g2g_vec_type word_i,
   output logic                      valid_ff,
   output g2g_pkg::g2g_vec_type      word_ff
);
   localparam logic signed [g2g_pkg::ANG_BITS-1:0] ATAN = g2g_pkg::atan_entry(STEP);

   g2g_pkg::g2g_vec_type word_in;
   logic signed [g2g_pkg::VEC_BITS-1:0] xs, ys;
   logic [g2g_pkg::ROOT_BITS+3:0] rem_sh;
   logic [g2g_pkg::ROOT_BITS+1:0] trial;

   always_comb begin
      word_in = word_i;
      xs      = word_i.x >>> STEP;
      ys      = word_i.y >>> STEP;
      rem_sh  = {word_i.rem[g2g_pkg::ROOT_BITS+1:0], word_i.q[g2g_pkg::SQ_BITS-1 -: 2]};
      trial   = {word_i.root, 2'b01};
      if (DO_ROT) begin
         if (word_i.y > 0) begin
            word_in.x   = word_i.x + ys;
            word_in.y   = word_i.y - xs;
            word_in.ang = word_i.ang + ATAN;
         end else begin
            word_in.x   = word_i.x - ys;
            word_in.y   = word_i.y + xs;
            word_in.ang = word_i.ang - ATAN;
         end
      end
      if (DO_ROOT) begin
         word_in.q = {word_i.q[g2g_pkg::SQ_BITS-3:0], 2'b00};
         if (rem_sh >= (g2g_pkg::ROOT_BITS+4)'(trial)) begin
            word_in.rem  = rem_sh - (g2g_pkg::ROOT_BITS+4)'(trial);
            word_in.root = {word_i.root[g2g_pkg::ROOT_BITS-2:0], 1'b1};
         end else begin
            word_in.rem  = rem_sh;
            word_in.root = {word_i.root[g2g_pkg::ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      word_ff <= word_in;
   end
endmodule
`default_nettype wire

// ===== rtl/g2g_div_stage.sv =====
// One pipeline stage of the speed ramp divider: one restoring quotient bit.
// Depends on g2g_pkg.
`default_nettype none
module g2g_div_stage #(
   parameter int unsigned BIT = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_i,
   input  wire g2g_pkg::g2g_div_type word_i,
   output logic                      valid_ff,
   output g2g_pkg::g2g_div_type      word_ff
);
   g2g_pkg::g2g_div_type word_in;
   logic [31:0] dsh;

   always_comb begin
      word_in = word_i;
      dsh     = 32'(word_i.slow) << BIT;
      if (word_i.rem >= dsh) begin
         word_in.rem      = word_i.rem - dsh;
         word_in.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      word_ff <= word_in;
   end
endmodule
`default_nettype wire

// ===== rtl/go_to_goal_steering_unit.sv =====
// Top level of the go-to-goal steering unit: offset, distance, bearing,
// heading error and speed ramp. Depends on g2g_pkg, g2g_vec_stage, g2g_div_stage.
//
//   channel   ports                      handshake
//   request   req_* , start, busy        word taken when start && !busy
//   response  rsp_*                      word shown for one cycle, rsp_valid
//   config    csr_we, csr_index, csr_wdata  written when csr_we
//
// A pose word enters every cycle; busy stays low. The square root takes 17
// digit stages alongside the CORDIC steps, and the ramp divider 15 bit stages.
// Reset clears the valid bits and loads the register defaults; nothing needs
// a clearing pass. The receiver cannot stall, so the pipeline always advances.
`default_nettype none
module go_to_goal_steering_unit #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_robot_x,
   input  wire logic signed [15:0] req_robot_y,
   input  wire logic signed [15:0] req_robot_yaw,
   input  wire logic signed [15:0] req_goal_x,
   input  wire logic signed [15:0] req_goal_y,
   input  wire logic signed [15:0] req_goal_yaw,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_angular_cmd,
   output logic [14:0]             rsp_linear_cmd,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   localparam int unsigned MID = (CORDIC_STEPS > g2g_pkg::ROOT_BITS) ?
                                 CORDIC_STEPS : g2g_pkg::ROOT_BITS;
   localparam int unsigned DIV = g2g_pkg::DIV_BITS;

   // configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
   logic [15:0] arrival_ff, slowdown_ff;
   logic [14:0] maxspeed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arrival_ff  <= 16'd50;
         slowdown_ff <= 16'd3000;
         maxspeed_ff <= 15'd3277;
      end else if (csr_we) begin
         case (csr_index)
            g2g_pkg::CSR_ARRIVAL:  arrival_ff  <= csr_wdata;
            g2g_pkg::CSR_SLOWDOWN: slowdown_ff <= csr_wdata;
            g2g_pkg::CSR_MAXSPEED: maxspeed_ff <= csr_wdata[14:0];
            default: ;   // drop writes to unknown indexes
         endcase
      end
   end

   assign busy = 1'b0;
   logic take;
   assign take = start && !busy;

   // stage 1: offset to goal
   g2g_pkg::g2g_diff_type diff_ff, diff_in;
   logic                  diff_v_ff;

   always_comb begin
      diff_in.dx   = $signed({req_goal_x[15], req_goal_x}) -
                     $signed({req_robot_x[15], req_robot_x});
      diff_in.dy   = $signed({req_goal_y[15], req_goal_y}) -
                     $signed({req_robot_y[15], req_robot_y});
      diff_in.ryaw = req_robot_yaw;
      diff_in.gyaw = req_goal_yaw;
   end

   // stage 2: squares, and turn the vector into the right half plane
   g2g_pkg::g2g_front_type front_ff, front_in;
   logic                   front_v_ff;
   logic signed [33:0]     px, py;
   logic signed [g2g_pkg::VEC_BITS-1:0] xe, ye;

   always_comb begin
      px  = diff_ff.dx * diff_ff.dx;
      py  = diff_ff.dy * diff_ff.dy;
      xe  = g2g_pkg::VEC_BITS'(diff_ff.dx) <<< 14;
      ye  = g2g_pkg::VEC_BITS'(diff_ff.dy) <<< 14;
      front_in.sqx  = px;
      front_in.sqy  = py;
      front_in.ryaw = diff_ff.ryaw;
      front_in.gyaw = diff_ff.gyaw;
      front_in.zero = (diff_ff.dx == 17'sd0) && (diff_ff.dy == 17'sd0);
      if (diff_ff.dx < 0) begin
         if (diff_ff.dy >= 0) begin
            front_in.x   = ye;
            front_in.y   = -xe;
            front_in.ang = 34'sd1073741824;
         end else begin
            front_in.x   = -ye;
            front_in.y   = xe;
            front_in.ang = -34'sd1073741824;
         end
      end else begin
         front_in.x   = xe;
         front_in.y   = ye;
         front_in.ang = '0;
      end
   end

   // stage 3: sum of squares, seed the root
   g2g_pkg::g2g_vec_type vec_w [MID+1];
   logic                 vec_v [MID+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_v_ff  <= 1'b0;
         front_v_ff <= 1'b0;
         vec_v[0]   <= 1'b0;
      end else begin
         diff_v_ff  <= take;
         front_v_ff <= diff_v_ff;
         vec_v[0]   <= front_v_ff;
      end
      diff_ff  <= diff_in;
      front_ff <= front_in;
      vec_w[0].x    <= front_ff.x;
      vec_w[0].y    <= front_ff.y;
      vec_w[0].ang  <= front_ff.ang;
      vec_w[0].zero <= front_ff.zero;
      vec_w[0].q    <= front_ff.sqx + front_ff.sqy;
      vec_w[0].rem  <= '0;
      vec_w[0].root <= '0;
      vec_w[0].ryaw <= front_ff.ryaw;
      vec_w[0].gyaw <= front_ff.gyaw;
   end

   // CORDIC steps and root digits, at most one of each per stage
   for (genvar j = 0; j < MID; j++) begin : g_vec
      g2g_vec_stage #(
         .STEP    (j),
         .DO_ROT  ((j < CORDIC_STEPS) && (j < g2g_pkg::ATAN_ENTRIES)),
         .DO_ROOT (j < g2g_pkg::ROOT_BITS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .valid_i  (vec_v[j]),
         .word_i   (vec_w[j]),
         .valid_ff (vec_v[j+1]),
         .word_ff  (vec_w[j+1])
      );
   end

   // heading error, wrap, scale; start the speed ramp
   g2g_pkg::g2g_vec_type last;
   g2g_pkg::g2g_div_type div_w [DIV+1];
   logic                 div_v [DIV+1];
   g2g_pkg::g2g_div_type end_in;
   logic signed [g2g_pkg::ANG_BITS-1:0] bear, err_b;
   logic [15:0]          yaw_diff;
   logic [31:0]          err_u;
   logic signed [32:0]   err_w;
   logic signed [33:0]   err_r, cmd_w;

   assign last = vec_w[MID];

   always_comb begin
      bear     = last.zero ? '0 : last.ang;
      err_b    = bear - (g2g_pkg::ANG_BITS'(last.ryaw) <<< 16);
      yaw_diff = last.gyaw - last.ryaw;
      if ({1'b0, last.root} < {2'b00, arrival_ff}) begin
         err_u = {yaw_diff, 16'h0000};
      end else begin
         err_u = err_b[31:0];
      end
      // wrap into (-pi, pi]
      if (err_u > 32'h8000_0000) begin
         err_w = $signed({1'b1, err_u});
      end else begin
         err_w = $signed({1'b0, err_u});
      end
      err_r = 34'(err_w) + 34'sd32768;
      cmd_w = err_r >>> 16;
      if (cmd_w > 34'sd32767) begin
         end_in.cmd = 16'sh7FFF;
      end else begin
         end_in.cmd = cmd_w[15:0];
      end
      end_in.rem  = 32'(maxspeed_ff) * 32'(last.root);
      end_in.quo  = '0;
      end_in.sat  = (slowdown_ff == 16'd0) ||
                    ({1'b0, last.root} >= {2'b00, slowdown_ff});
      end_in.maxv = maxspeed_ff;
      end_in.slow = slowdown_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v[0] <= 1'b0;
      end else begin
         div_v[0] <= vec_v[MID];
      end
      div_w[0] <= end_in;
   end

   // ramp divider, most significant quotient bit first
   for (genvar k = 0; k < DIV; k++) begin : g_div
      g2g_div_stage #(
         .BIT (DIV-1-k)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .valid_i  (div_v[k]),
         .word_i   (div_w[k]),
         .valid_ff (div_v[k+1]),
         .word_ff  (div_w[k+1])
      );
   end

   assign rsp_valid       = div_v[DIV];
   assign rsp_angular_cmd = div_w[DIV].cmd;
   assign rsp_linear_cmd  = div_w[DIV].sat ? div_w[DIV].maxv : div_w[DIV].quo;

`ifndef SYNTH
   // ramp quotient never exceeds the saturated speed
   a_ramp_bound: assert property (@(posedge clock) disable iff (reset)
      (div_v[DIV] && !div_w[DIV].sat) |-> (div_w[DIV].quo <= div_w[DIV].maxv))
      else $error("ramp quotient above maximum speed");
   // square root remainder stays within 2 * root
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      vec_v[MID] |-> (last.rem <= {2'b00, last.root, 1'b0}))
      else $error("square root remainder out of range");
`endif
endmodule
`default_nettype wire
